// ===== src/page_table_map_translate_find_defines.svh =====
// Assertion macros for the page table block.
// No dependencies; included by the top level.
`ifndef PAGE_TABLE_MAP_TRANSLATE_FIND_DEFINES_SVH
`define PAGE_TABLE_MAP_TRANSLATE_FIND_DEFINES_SVH
`ifndef SYNTH
`define PTMTF_ASSERT(lbl, c, r, prop, msg) \
	lbl: assert property (@(posedge c) disable iff (!r) (prop)) else $error(msg);
`define PTMTF_ASSERT_ALWAYS(lbl, c, prop, msg) \
	lbl: assert property (@(posedge c) (prop)) else $error(msg);
`else
`define PTMTF_ASSERT(lbl, c, r, prop, msg)
`define PTMTF_ASSERT_ALWAYS(lbl, c, prop, msg)
`endif
`endif

// ===== src/ptmtf_pkg.sv =====
// Types and codes for the page table block.
// No dependencies; used by the interfaces, the datapath, the controller and the top level.
package ptmtf_pkg;

	localparam int BLOCK_W = 11;

	localparam logic [1:0] REQ_MAP   = 2'd0;
	localparam logic [1:0] REQ_UNMAP = 2'd1;
	localparam logic [1:0] REQ_XLATE = 2'd2;
	localparam logic [1:0] REQ_FIND  = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFRAME = 2'd1;
	localparam logic [1:0] ST_NOBLOCK = 2'd2;
	localparam logic [1:0] ST_REFUSED = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [9:0]         page_index;
		logic [21:0]        virt_addr;
		logic [19:0]        frame;
		logic               shared;
		logic [15:0]        segment_id;
		logic [19:0]        seg_page_off;
		logic               offset_valid;
		logic [BLOCK_W-1:0] block_pages;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] phys_addr;
		logic [21:0] block_addr;
		logic        released_valid;
		logic [19:0] released_frame;
		logic [15:0] released_segment;
		logic [19:0] released_offset;
	} rsp_t;

	typedef struct packed {
		logic rd_en;
		logic rd_scan;
		logic clr_wr;
		logic clr_inc;
		logic latch_req;
		logic load_exec;
		logic load_find_ok;
		logic load_find_none;
		logic blk_init;
		logic blk_skip;
		logic pg_init;
		logic pg_inc;
	} cmd_t;

	typedef struct packed {
		logic [1:0] in_req;
		logic       clr_last;
		logic       blk_over;
		logic       used;
		logic       run_end;
	} sts_t;

endpackage

// ===== src/ptmtf_ifs.sv =====
// Request and response channel interfaces for the page table block.
// Depends on ptmtf_pkg.
interface ptmtf_req_if;
	import ptmtf_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ptmtf_rsp_if;
	import ptmtf_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/ptmtf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ptmtf_ram #(
	parameter int WIDTH = 58,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ===== src/ptmtf_dp.sv =====
// Datapath: page table RAM, request and scan registers, result register.
// Depends on ptmtf_pkg and ptmtf_ram.
module ptmtf_dp #(
	parameter int PAGE_COUNT  = 1024,
	parameter int PAGE_BITS   = 12,
	parameter int FRAME_WIDTH = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ptmtf_pkg::req_t   req_data,
	input  ptmtf_pkg::cmd_t   cmd,
	output ptmtf_pkg::sts_t   sts,
	output ptmtf_pkg::rsp_t   rsp_data
);
	import ptmtf_pkg::*;

	localparam int AW     = $clog2(PAGE_COUNT);
	localparam int CW     = AW + 1;
	localparam int SW     = ((CW > BLOCK_W) ? CW : BLOCK_W) + 1;
	localparam int EW     = FRAME_WIDTH + 38;
	localparam int SEG_LO = FRAME_WIDTH + 1;
	localparam int OFF_LO = FRAME_WIDTH + 17;
	localparam int OK_POS = FRAME_WIDTH + 37;

	req_t             req_q;
	logic [AW-1:0]    clr_q;
	logic [CW-1:0]    blk_q;
	logic [CW-1:0]    pg_q;
	rsp_t             rsp_q;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [EW-1:0]    wr_data;
	logic [AW-1:0]    rd_addr;
	logic [EW-1:0]    rd_data;

	logic [31:0]      pn_in;
	logic [31:0]      vp_in;
	logic [31:0]      pn_q32;
	logic [31:0]      vp_q32;
	logic [31:0]      byte_off;
	logic             refused;
	logic             is_mu;
	logic [FRAME_WIDTH-1:0] ent_frame;
	logic [FRAME_WIDTH-1:0] xl_frame;
	logic             ent_used;
	logic [BLOCK_W-1:0] want_m1;
	logic [BLOCK_W-1:0] mask;
	logic [SW-1:0]    mask_ext;
	logic [SW-1:0]    pg_ext;
	rsp_t             rsp_exec;
	rsp_t             rsp_find;

	always_comb begin
		pn_in   = 32'(req_data.page_index);
		vp_in   = 32'(req_data.virt_addr) >> PAGE_BITS;
		rd_addr = cmd.rd_scan ? pg_q[AW-1:0] :
			((req_data.req_type == REQ_XLATE) ? vp_in[AW-1:0] : pn_in[AW-1:0]);
	end

	always_comb begin
		want_m1 = (req_q.block_pages == '0) ? '0 : (req_q.block_pages - 1'b1);
		for (int i = 0; i < BLOCK_W; i++) begin
			mask[i] = |(want_m1 >> i);
		end
		mask_ext = SW'(mask);
		pg_ext   = SW'(pg_q);
	end

	always_comb begin
		pn_q32    = 32'(req_q.page_index);
		vp_q32    = 32'(req_q.virt_addr) >> PAGE_BITS;
		byte_off  = 32'(req_q.virt_addr) & ((32'd1 << PAGE_BITS) - 32'd1);
		refused   = (pn_q32 == 32'd0) || (pn_q32 >= 32'(PAGE_COUNT));
		is_mu     = (req_q.req_type == REQ_MAP) || (req_q.req_type == REQ_UNMAP);
		ent_frame = rd_data[FRAME_WIDTH-1:0];
		ent_used  = (ent_frame != '0);
		xl_frame  = (vp_q32 < 32'(PAGE_COUNT)) ? ent_frame : '0;

		rsp_exec = '0;
		if (is_mu) begin
			if (refused) begin
				rsp_exec.status = ST_REFUSED;
			end else begin
				rsp_exec.status = ST_OK;
				if (ent_used) begin
					rsp_exec.released_valid   = 1'b1;
					rsp_exec.released_frame   = 20'(ent_frame);
					rsp_exec.released_segment = rd_data[SEG_LO +: 16];
					rsp_exec.released_offset  = rd_data[OK_POS] ?
						rd_data[OFF_LO +: 20] : '1;
				end
			end
		end else begin
			rsp_exec.status    = (xl_frame <= FRAME_WIDTH'(1)) ? ST_NOFRAME : ST_OK;
			rsp_exec.phys_addr = 32'((64'(xl_frame) << PAGE_BITS) | 64'(byte_off));
		end

		rsp_find = '0;
		if (cmd.load_find_ok) begin
			rsp_find.block_addr = 22'(64'(blk_q) << PAGE_BITS);
		end else begin
			rsp_find.status = ST_NOBLOCK;
		end
	end

	always_comb begin
		wr_en   = cmd.clr_wr || (cmd.load_exec && is_mu && !refused);
		wr_addr = cmd.clr_wr ? clr_q : pn_q32[AW-1:0];
		if (cmd.clr_wr) begin
			wr_data = {1'b0, 20'd0, 16'd0, 1'b0, FRAME_WIDTH'(clr_q == '0)};
		end else if (req_q.req_type == REQ_MAP) begin
			wr_data = {req_q.offset_valid,
				(req_q.offset_valid ? req_q.seg_page_off : 20'd0),
				req_q.segment_id, req_q.shared, FRAME_WIDTH'(req_q.frame)};
		end else begin
			wr_data = '0;
		end
	end

	ptmtf_ram #(
		.WIDTH (EW),
		.DEPTH (PAGE_COUNT)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			blk_q <= '0;
			pg_q  <= '0;
		end else begin
			if (cmd.clr_inc) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.blk_init) begin
				blk_q <= '0;
			end else if (cmd.blk_skip) begin
				blk_q <= CW'((pg_ext | mask_ext) + 1'b1);
			end
			if (cmd.pg_init) begin
				pg_q <= blk_q;
			end else if (cmd.pg_inc) begin
				pg_q <= pg_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q <= req_data;
		end
		if (cmd.load_exec) begin
			rsp_q <= rsp_exec;
		end else if (cmd.load_find_ok || cmd.load_find_none) begin
			rsp_q <= rsp_find;
		end
	end

	always_comb begin
		sts.in_req   = req_data.req_type;
		sts.clr_last = (clr_q == AW'(PAGE_COUNT - 1));
		sts.blk_over = (SW'(blk_q) + mask_ext) >= SW'(PAGE_COUNT);
		sts.used     = ent_used;
		sts.run_end  = ((pg_ext & mask_ext) == mask_ext);
	end

	assign rsp_data = rsp_q;
endmodule

// ===== src/ptmtf_ctrl.sv =====
// Controller: sequences table clearing, lookups, updates and block search.
// Depends on ptmtf_pkg.
module ptmtf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  ptmtf_pkg::sts_t sts,
	output ptmtf_pkg::cmd_t cmd
);
	import ptmtf_pkg::*;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_FSTART = 3'd3;
	localparam logic [2:0] S_FRD    = 3'd4;
	localparam logic [2:0] S_FCHK   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;
	logic       load;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr  = 1'b1;
				cmd.clr_inc = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_req = 1'b1;
					if (sts.in_req == REQ_FIND) begin
						cmd.blk_init = 1'b1;
						state_nxt    = S_FSTART;
					end else begin
						cmd.rd_en = 1'b1;
						state_nxt = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				if (out_free) begin
					cmd.load_exec = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			S_FSTART: begin
				if (sts.blk_over) begin
					if (out_free) begin
						cmd.load_find_none = 1'b1;
						state_nxt          = S_IDLE;
					end
				end else begin
					cmd.pg_init = 1'b1;
					state_nxt   = S_FRD;
				end
			end
			S_FRD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_scan = 1'b1;
				state_nxt   = S_FCHK;
			end
			S_FCHK: begin
				if (sts.used) begin
					cmd.blk_skip = 1'b1;
					state_nxt    = S_FSTART;
				end else if (sts.run_end) begin
					if (out_free) begin
						cmd.load_find_ok = 1'b1;
						state_nxt        = S_IDLE;
					end
				end else begin
					cmd.pg_inc = 1'b1;
					state_nxt  = S_FRD;
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	assign load = cmd.load_exec || cmd.load_find_ok || cmd.load_find_none;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

// ===== src/page_table_map_translate_find.sv =====
// Top level of the page table block: controller, datapath and checks.
// Depends on ptmtf_pkg, ptmtf_ifs, ptmtf_ctrl, ptmtf_dp and the defines header.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   ptmtf_pkg::req_t
//   rsp      out  valid/ready   ptmtf_pkg::rsp_t
//
// Map, unmap and translate: a table read, then the update and the result.
// Find: tries aligned blocks in turn, skipping a block at its first used page; one RAM read per page.
// After reset a clearing pass writes every entry, with req.ready low.
// A result held in the output register stalls the next item only at its result step.
`include "page_table_map_translate_find_defines.svh"
module page_table_map_translate_find #(
	parameter int PAGE_COUNT  = 1024,
	parameter int PAGE_BITS   = 12,
	parameter int FRAME_WIDTH = 20
) (
	input logic       clk,
	input logic       arst_n,
	ptmtf_req_if.sink   req,
	ptmtf_rsp_if.source rsp
);
	import ptmtf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ptmtf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ptmtf_dp #(
		.PAGE_COUNT  (PAGE_COUNT),
		.PAGE_BITS   (PAGE_BITS),
		.FRAME_WIDTH (FRAME_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_data (rsp.data)
	);

	`PTMTF_ASSERT(a_clear_blocks_req, clk, arst_n, cmd.clr_wr |-> !req.ready, "item taken during clear")
	`PTMTF_ASSERT(a_load_slot_free, clk, arst_n, (cmd.load_exec || cmd.load_find_ok || cmd.load_find_none) |-> (!rsp.valid || rsp.ready), "result overwrites pending item")
	`PTMTF_ASSERT(a_one_at_a_time, clk, arst_n, (req.valid && req.ready) |=> !req.ready, "second item taken while busy")
	`PTMTF_ASSERT_ALWAYS(a_single_load, clk, $onehot0({cmd.load_exec, cmd.load_find_ok, cmd.load_find_none}), "more than one result load")
endmodule
